// ===== sv/cfsac_pkg.sv =====
// ============================================================================
// Command frame sender and ack checker package
// Shared types, codes and constants of the command frame sender core.
// ============================================================================
package cfsac_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int RX_LEN      = 64;
    localparam int PAY_AW      = $clog2(MAX_PAYLOAD);
    localparam int RX_CNT_W    = $clog2(RX_LEN);
    localparam int HDR_BYTES   = 7;
    localparam int ACK_BYTES   = 4;

    localparam logic [7:0] SYNC_A = 8'hAA;
    localparam logic [7:0] SYNC_B = 8'h55;
    localparam logic [7:0] LEN_EXTRA = 8'h04;

    localparam logic [7:0] SOURCE_ID_RESET = 8'h20;
    localparam logic [7:0] DEST_ID_RESET   = 8'h21;
    localparam logic [3:0] ACK_POLLS_RESET = 4'h4;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_SEND  = 2'd1,
        CMD_RX    = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_SOURCE_ID = 2'd0,
        REG_DEST_ID   = 2'd1,
        REG_ACK_POLLS = 2'd2
    } reg_index_t;

    typedef enum logic {
        KIND_TX     = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STS_SUCCESS = 2'd0,
        STS_TIMEOUT = 2'd1,
        STS_BAD_ACK = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_FRAME,
        FSM_STATUS
    } fsm_state_t;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] payload_byte;
        logic [4:0] payload_index;
        logic [7:0] opcode;
        logic       need_ack;
        logic [5:0] payload_count;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic accept;
        logic frame_step;
        logic status_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic frame_end;
        logic need_status;
    } dp_status_t;

endpackage

// ===== sv/cfsac_ctrl.sv =====
// ============================================================================
// Command frame sender controller
// Sequences item acceptance, frame emission and the trailing status request.
// ============================================================================
module cfsac_ctrl
    import cfsac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  cmd_t       in_command,
    output logic       in_ready,
    input  dp_status_t dp_stat,
    output ctrl_cmd_t  ctrl
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            FSM_IDLE:
            begin
                in_ready = dp_stat.out_free;
                if (in_valid && dp_stat.out_free)
                begin
                    ctrl.accept = 1'b1;
                    if (in_command == CMD_SEND)
                    begin
                        state_next = FSM_FRAME;
                    end
                end
            end
            FSM_FRAME:
            begin
                if (dp_stat.out_free)
                begin
                    ctrl.frame_step = 1'b1;
                    if (dp_stat.frame_end)
                    begin
                        state_next = dp_stat.need_status ? FSM_STATUS : FSM_IDLE;
                    end
                end
            end
            FSM_STATUS:
            begin
                if (dp_stat.out_free)
                begin
                    ctrl.status_step = 1'b1;
                    state_next       = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/cfsac_dp.sv =====
// ============================================================================
// Command frame sender datapath
// Payload store, frame byte selection, parity, receive head and ack check.
// ============================================================================
module cfsac_dp
    import cfsac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       item,
    input  ctrl_cmd_t   ctrl,
    output dp_status_t  dp_stat,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output status_t     out_status,
    output kind_t       out_kind,
    output logic        out_last
);

    logic [7:0] store [MAX_PAYLOAD];

    logic [7:0] source_id_reg;
    logic [7:0] dest_id_reg;
    logic [3:0] ack_polls_reg;

    logic [7:0]          rx_head_reg [ACK_BYTES];
    logic [RX_CNT_W-1:0] rx_count_reg;
    logic                awaiting_reg;
    logic [3:0]          polls_reg;
    logic [7:0]          exp_len_reg;
    logic [7:0]          exp_par_reg;

    logic [5:0] n_reg;
    logic [5:0] pos_reg;
    logic [7:0] op_reg;
    logic       ack_reg;
    logic [7:0] len_reg;
    logic [7:0] par_reg;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    status_t    out_status_reg;
    status_t    out_status_next;
    kind_t      out_kind_reg;
    kind_t      out_kind_next;
    logic       out_last_reg;
    logic       out_last_next;
    logic       out_load;

    logic [5:0]        n_sat;
    logic [7:0]        len_new;
    logic [5:0]        pay_end;
    logic [5:0]        tail;
    logic [5:0]        pay_off;
    logic              in_payload;
    logic [7:0]        frame_byte;
    logic              need_status;
    logic [RX_CNT_W:0] rx_inc;
    logic [3:0]        polls_dec;
    logic              ack_ok;
    logic              tick_emit;
    status_t           tick_status;

    assign n_sat   = (item.payload_count > 6'(MAX_PAYLOAD)) ? 6'(MAX_PAYLOAD)
                                                            : item.payload_count;
    assign len_new = {2'b00, n_sat} + LEN_EXTRA;
    assign pay_end = n_reg + 6'(HDR_BYTES);
    assign tail    = pos_reg - pay_end;
    assign pay_off = pos_reg - 6'(HDR_BYTES);
    assign in_payload  = (pos_reg >= 6'(HDR_BYTES)) && (pos_reg < pay_end);
    assign need_status = !ack_reg || (ack_polls_reg == 4'd0);

    always_comb
    begin
        frame_byte = SYNC_A;
        if (pos_reg < 6'(HDR_BYTES))
        begin
            case (pos_reg[2:0])
                3'd0:    frame_byte = SYNC_A;
                3'd1:    frame_byte = SYNC_B;
                3'd2:    frame_byte = len_reg;
                3'd3:    frame_byte = source_id_reg;
                3'd4:    frame_byte = dest_id_reg;
                3'd5:    frame_byte = {7'd0, ack_reg};
                3'd6:    frame_byte = op_reg;
                default: frame_byte = SYNC_A;
            endcase
        end
        else if (in_payload)
        begin
            frame_byte = store[pay_off[PAY_AW-1:0]];
        end
        else
        begin
            case (tail[1:0])
                2'd0:    frame_byte = par_reg;
                2'd1:    frame_byte = SYNC_B;
                default: frame_byte = SYNC_A;
            endcase
        end
    end

    assign rx_inc    = {1'b0, rx_count_reg} + 1'b1;
    assign polls_dec = (polls_reg != 4'd0) ? polls_reg - 4'd1 : 4'd0;
    assign ack_ok    = (rx_head_reg[0] == dest_id_reg) && (rx_head_reg[1] == source_id_reg)
                    && (rx_head_reg[2] == exp_len_reg) && (rx_head_reg[3] == exp_par_reg);

    always_comb
    begin
        tick_emit   = 1'b0;
        tick_status = STS_TIMEOUT;
        if (awaiting_reg)
        begin
            if (rx_count_reg >= RX_CNT_W'(ACK_BYTES))
            begin
                tick_emit   = 1'b1;
                tick_status = ack_ok ? STS_SUCCESS : STS_BAD_ACK;
            end
            else if (polls_dec == 4'd0)
            begin
                tick_emit = 1'b1;
            end
        end
    end

    assign out_load = ctrl.frame_step || ctrl.status_step
                   || (ctrl.accept && (item.command == CMD_TICK) && tick_emit);

    always_comb
    begin
        out_byte_next   = 8'd0;
        out_status_next = STS_SUCCESS;
        out_kind_next   = KIND_STATUS;
        out_last_next   = 1'b1;
        if (ctrl.frame_step)
        begin
            out_byte_next = frame_byte;
            out_kind_next = KIND_TX;
            out_last_next = (pos_reg == pay_end + 6'd2) && !need_status;
        end
        else if (ctrl.status_step)
        begin
            out_status_next = ack_reg ? STS_TIMEOUT : STS_SUCCESS;
        end
        else
        begin
            out_status_next = tick_status;
        end
        out_valid_next = out_load || (out_valid_reg && !out_ready);
    end

    assign dp_stat.out_free    = !out_valid_reg || out_ready;
    assign dp_stat.frame_end   = (pos_reg == pay_end + 6'd2);
    assign dp_stat.need_status = need_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_id_reg <= SOURCE_ID_RESET;
            dest_id_reg   <= DEST_ID_RESET;
            ack_polls_reg <= ACK_POLLS_RESET;
            out_valid_reg <= 1'b0;
            rx_count_reg  <= '0;
            awaiting_reg  <= 1'b0;
            polls_reg     <= 4'd0;
            exp_len_reg   <= 8'd0;
            exp_par_reg   <= 8'd0;
            for (int i = 0; i < ACK_BYTES; i++)
            begin
                rx_head_reg[i] <= 8'd0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SOURCE_ID: source_id_reg <= cfg_data;
                    REG_DEST_ID:   dest_id_reg   <= cfg_data;
                    REG_ACK_POLLS: ack_polls_reg <= cfg_data[3:0];
                    default:       ;
                endcase
            end
            if (ctrl.accept)
            begin
                unique case (item.command)
                    CMD_SEND:
                    begin
                        rx_count_reg <= '0;
                        awaiting_reg <= 1'b0;
                        polls_reg    <= 4'd0;
                        exp_len_reg  <= len_new;
                        for (int i = 0; i < ACK_BYTES; i++)
                        begin
                            rx_head_reg[i] <= 8'd0;
                        end
                    end
                    CMD_RX:
                    begin
                        if (rx_count_reg < RX_CNT_W'(ACK_BYTES))
                        begin
                            rx_head_reg[rx_count_reg[1:0]] <= item.rx_byte;
                        end
                        rx_count_reg <= (rx_inc > (RX_CNT_W+1)'(RX_LEN - 1))
                                        ? '0 : rx_inc[RX_CNT_W-1:0];
                    end
                    CMD_TICK:
                    begin
                        if (awaiting_reg)
                        begin
                            if (rx_count_reg >= RX_CNT_W'(ACK_BYTES))
                            begin
                                awaiting_reg <= 1'b0;
                                polls_reg    <= 4'd0;
                            end
                            else
                            begin
                                polls_reg <= polls_dec;
                                if (polls_dec == 4'd0)
                                begin
                                    awaiting_reg <= 1'b0;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (ctrl.frame_step)
            begin
                if (pos_reg == pay_end)
                begin
                    exp_par_reg <= par_reg;
                end
                if (dp_stat.frame_end && !need_status)
                begin
                    awaiting_reg <= 1'b1;
                    polls_reg    <= ack_polls_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept && (item.command == CMD_WRITE))
        begin
            store[item.payload_index] <= item.payload_byte;
        end
        if (ctrl.accept && (item.command == CMD_SEND))
        begin
            n_reg   <= n_sat;
            pos_reg <= 6'd0;
            op_reg  <= item.opcode;
            ack_reg <= item.need_ack;
            len_reg <= len_new;
            par_reg <= len_new ^ source_id_reg ^ dest_id_reg
                     ^ {7'd0, item.need_ack} ^ item.opcode;
        end
        else if (ctrl.frame_step)
        begin
            pos_reg <= pos_reg + 6'd1;
            if (in_payload)
            begin
                par_reg <= par_reg ^ frame_byte;
            end
        end
        if (out_load)
        begin
            out_byte_reg   <= out_byte_next;
            out_status_reg <= out_status_next;
            out_kind_reg   <= out_kind_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_status = out_status_reg;
    assign out_kind   = out_kind_reg;
    assign out_last   = out_last_reg;

endmodule

// ===== sv/command_frame_sender_ack_checker_core.sv =====
// ============================================================================
// Command frame sender and ack checker core
// Builds command frames from a payload store and checks the slave's ack.
// ============================================================================
// A send request emits n + 10 frame bytes, one per cycle unless the output stalls,
// plus one status result when no ack is requested or the poll count is zero, and
// holds the input until its last result is loaded. A tick status appears in the
// cycle after acceptance; the first frame byte passes the frame state and then the
// output register. Reset clears the receive head and count, poll counter, ack state
// and output valid flag and loads the default identifiers and poll count.
module command_frame_sender_ack_checker_core
    import cfsac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // payload_byte, payload_index, opcode, need_ack, payload_count, rx_byte
    input  logic [39:0] s_axis_tdata,
    // command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_byte, status
    output logic [15:0] m_axis_tdata,
    // kind
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    item_t      item;
    ctrl_cmd_t  ctrl;
    dp_status_t dp_stat;
    logic [7:0] out_byte;
    status_t    out_status;
    kind_t      out_kind;

    assign item.command       = cmd_t'(s_axis_tuser);
    assign item.payload_byte  = s_axis_tdata[7:0];
    assign item.payload_index = s_axis_tdata[12:8];
    assign item.opcode        = s_axis_tdata[20:13];
    assign item.need_ack      = s_axis_tdata[21];
    assign item.payload_count = s_axis_tdata[27:22];
    assign item.rx_byte       = s_axis_tdata[35:28];

    assign cfg_ready = 1'b1;

    cfsac_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_command (item.command),
        .in_ready   (s_axis_tready),
        .dp_stat    (dp_stat),
        .ctrl       (ctrl)
    );

    cfsac_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .ctrl       (ctrl),
        .dp_stat    (dp_stat),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (out_byte),
        .out_status (out_status),
        .out_kind   (out_kind),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, out_status, out_byte};
    assign m_axis_tuser = out_kind;

endmodule

// ===== sv/cfsac_checker.sv =====
// ============================================================================
// Command frame sender port checker
// Port-level properties of the core, bound to the top level.
// ============================================================================
module cfsac_checker
    import cfsac_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result keeps its contents until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // No request is taken while a result is stalled at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken during output stall");

    // A status result always closes the results of its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
        else $error("status result malformed");

    // Transmit results carry no status and status codes stay in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[9:8] != 2'd3
            && (m_axis_tuser || m_axis_tdata[9:8] == 2'd0))
        else $error("bad status field");

endmodule

bind command_frame_sender_ack_checker_core cfsac_checker u_cfsac_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Command frame sender and ack checker testbench
// Streams payload writes, send requests, received bytes and poll ticks into
// the core under random stalls on both sides. A scoreboard predicts every
// frame byte and exchange status and checks each result in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cfsac_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 64;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic [1:0] status;
        logic       last;
    } link_result_t;

    class frame_scoreboard;
        link_result_t due_results[$];
        int           errors;
        logic [7:0]   pay_mem [MAX_PAYLOAD];
        logic [7:0]   ack_head [ACK_BYTES];
        int           rx_cnt;
        bit           awaiting;
        logic [3:0]   polls_left;
        logic [7:0]   exp_len;
        logic [7:0]   exp_par;
        logic [7:0]   src_id;
        logic [7:0]   dst_id;
        logic [3:0]   poll_limit;

        function new();
            foreach (pay_mem[i]) pay_mem[i] = 8'h00;
            foreach (ack_head[i]) ack_head[i] = 8'h00;
            errors     = 0;
            rx_cnt     = 0;
            awaiting   = 1'b0;
            polls_left = 4'd0;
            exp_len    = 8'h00;
            exp_par    = 8'h00;
            src_id     = SOURCE_ID_RESET;
            dst_id     = DEST_ID_RESET;
            poll_limit = ACK_POLLS_RESET;
        endfunction

        function void report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endfunction

        function void set_reg(reg_index_t idx, logic [7:0] data);
            case (idx)
                REG_SOURCE_ID: src_id = data;
                REG_DEST_ID:   dst_id = data;
                REG_ACK_POLLS: poll_limit = data[3:0];
                default: ;
            endcase
        endfunction

        function void add(logic kind, logic [7:0] b, logic [1:0] st, logic last);
            link_result_t r;
            r.kind    = kind;
            r.tx_byte = b;
            r.status  = st;
            r.last    = last;
            due_results.push_back(r);
        endfunction

        function void note_request(item_t req);
            int           n;
            logic [7:0]   len;
            logic [7:0]   par;
            bit           ok;
            link_result_t r;
            case (req.command)
                CMD_WRITE: pay_mem[req.payload_index] = req.payload_byte;
                CMD_SEND:
                begin
                    n   = (req.payload_count > MAX_PAYLOAD) ? MAX_PAYLOAD : req.payload_count;
                    len = 8'(n + 4);
                    par = len ^ src_id ^ dst_id ^ {7'd0, req.need_ack} ^ req.opcode;
                    add(KIND_TX, SYNC_A, STS_SUCCESS, 1'b0);
                    add(KIND_TX, SYNC_B, STS_SUCCESS, 1'b0);
                    add(KIND_TX, len, STS_SUCCESS, 1'b0);
                    add(KIND_TX, src_id, STS_SUCCESS, 1'b0);
                    add(KIND_TX, dst_id, STS_SUCCESS, 1'b0);
                    add(KIND_TX, {7'd0, req.need_ack}, STS_SUCCESS, 1'b0);
                    add(KIND_TX, req.opcode, STS_SUCCESS, 1'b0);
                    for (int i = 0; i < n; i++)
                    begin
                        par ^= pay_mem[i];
                        add(KIND_TX, pay_mem[i], STS_SUCCESS, 1'b0);
                    end
                    add(KIND_TX, par, STS_SUCCESS, 1'b0);
                    add(KIND_TX, SYNC_B, STS_SUCCESS, 1'b0);
                    add(KIND_TX, SYNC_A, STS_SUCCESS, 1'b0);
                    foreach (ack_head[i]) ack_head[i] = 8'h00;
                    rx_cnt  = 0;
                    exp_len = len;
                    exp_par = par;
                    if (!req.need_ack)
                    begin
                        awaiting   = 1'b0;
                        polls_left = 4'd0;
                        add(KIND_STATUS, 8'h00, STS_SUCCESS, 1'b1);
                    end
                    else if (poll_limit == 4'd0)
                    begin
                        awaiting   = 1'b0;
                        polls_left = 4'd0;
                        add(KIND_STATUS, 8'h00, STS_TIMEOUT, 1'b1);
                    end
                    else
                    begin
                        awaiting   = 1'b1;
                        polls_left = poll_limit;
                        r = due_results.pop_back();
                        r.last = 1'b1;
                        due_results.push_back(r);
                    end
                end
                CMD_RX:
                begin
                    if (rx_cnt < ACK_BYTES)
                        ack_head[rx_cnt] = req.rx_byte;
                    rx_cnt++;
                    if (rx_cnt > RX_LEN - 1)
                        rx_cnt = 0;
                end
                default:
                begin
                    if (awaiting)
                    begin
                        if (rx_cnt >= ACK_BYTES)
                        begin
                            ok = ack_head[0] == dst_id && ack_head[1] == src_id &&
                                 ack_head[2] == exp_len && ack_head[3] == exp_par;
                            awaiting   = 1'b0;
                            polls_left = 4'd0;
                            add(KIND_STATUS, 8'h00, ok ? STS_SUCCESS : STS_BAD_ACK, 1'b1);
                        end
                        else
                        begin
                            if (polls_left != 4'd0)
                                polls_left--;
                            if (polls_left == 4'd0)
                            begin
                                awaiting = 1'b0;
                                add(KIND_STATUS, 8'h00, STS_TIMEOUT, 1'b1);
                            end
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(link_result_t got);
            link_result_t want;
            if (due_results.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d byte %02h status %0d last %0d",
                                 got.kind, got.tx_byte, got.status, got.last));
                return;
            end
            want = due_results.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, predicted %0d", got.kind, want.kind));
            if (got.tx_byte !== want.tx_byte)
                report($sformatf("tx_byte %02h, predicted %02h", got.tx_byte, want.tx_byte));
            if (got.status !== want.status)
                report($sformatf("status %0d, predicted %0d", got.status, want.status));
            if (got.last !== want.last)
                report($sformatf("last %0d, predicted %0d", got.last, want.last));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = CMD_WRITE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_SOURCE_ID;
    logic [7:0]  cfg_data = 8'h00;

    frame_scoreboard sb = new();
    bit              written [MAX_PAYLOAD];
    int              work_items = 0;
    int              quiet_cycles = 0;
    bit              tx_idle = 1'b0;
    bit              rx_idle = 1'b0;
    bit              hold_req = 1'b0;

    command_frame_sender_ack_checker_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (rx_idle && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result({m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[9:8],
                                 m_axis_tlast});
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[command_frame_sender_ack_checker_core] ERROR");
                $finish;
            end
        end
    end

    function automatic item_t rand_req(cmd_t c);
        item_t r;
        r.command       = c;
        r.payload_byte  = 8'($urandom);
        r.payload_index = 5'($urandom);
        r.opcode        = 8'($urandom);
        r.need_ack      = 1'($urandom);
        r.payload_count = 6'($urandom_range(0, 63));
        r.rx_byte       = 8'($urandom);
        return r;
    endfunction

    function automatic int written_prefix();
        int n;
        n = 0;
        while (n < MAX_PAYLOAD && written[n])
            n++;
        return n;
    endfunction

    task automatic push_request(item_t req);
        if (tx_idle && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, req.rx_byte, req.payload_count, req.need_ack, req.opcode,
                          req.payload_index, req.payload_byte};
        s_axis_tuser  <= req.command;
        do @(posedge clk); while (!s_axis_tready);
        if (!(req.command == CMD_TICK && !sb.awaiting))
            work_items++;
        sb.note_request(req);
        if (req.command == CMD_WRITE)
            written[req.payload_index] = 1'b1;
    endtask

    task automatic write_payload(int idx, logic [7:0] b);
        item_t req;
        req = rand_req(CMD_WRITE);
        req.payload_index = idx[4:0];
        req.payload_byte  = b;
        push_request(req);
    endtask

    task automatic send_frame(int count, bit ack, logic [7:0] op);
        item_t req;
        req = rand_req(CMD_SEND);
        req.payload_count = count[5:0];
        req.need_ack      = ack;
        req.opcode        = op;
        push_request(req);
    endtask

    task automatic feed_rx(logic [7:0] b);
        item_t req;
        req = rand_req(CMD_RX);
        req.rx_byte = b;
        push_request(req);
    endtask

    task automatic poll_tick();
        push_request(rand_req(CMD_TICK));
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic configure(logic [7:0] src, logic [7:0] dst, logic [7:0] polls);
        settle();
        write_reg(REG_SOURCE_ID, src);
        write_reg(REG_DEST_ID, dst);
        write_reg(REG_ACK_POLLS, polls);
        cfg_valid <= 1'b0;
    endtask

    task automatic answer_ack(int mode);
        logic [7:0] reply [ACK_BYTES];
        int         bad;
        reply[0] = sb.dst_id;
        reply[1] = sb.src_id;
        reply[2] = sb.exp_len;
        reply[3] = sb.exp_par;
        case (mode)
            0:
            begin
                repeat ($urandom_range(0, sb.poll_limit)) poll_tick();
                foreach (reply[i]) feed_rx(reply[i]);
                poll_tick();
            end
            1:
            begin
                bad = $urandom_range(0, ACK_BYTES - 1);
                reply[bad] ^= 8'($urandom_range(1, 255));
                foreach (reply[i]) feed_rx(reply[i]);
                poll_tick();
            end
            2: repeat (sb.poll_limit) poll_tick();
            3:
            begin
                repeat ($urandom_range(1, ACK_BYTES - 1)) feed_rx(8'($urandom));
                repeat (sb.poll_limit) poll_tick();
            end
            default:
            begin
                foreach (reply[i]) feed_rx(reply[i]);
                repeat ($urandom_range(1, 6)) feed_rx(8'($urandom));
                poll_tick();
            end
        endcase
    endtask

    task automatic exchange();
        int n;
        int pick;
        bit ack;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            n = $urandom_range(0, 8);
        else if (pick < 88)
            n = $urandom_range(9, MAX_PAYLOAD - 1);
        else if (written_prefix() == MAX_PAYLOAD && $urandom_range(0, 1))
            n = $urandom_range(MAX_PAYLOAD + 1, 63);
        else
            n = MAX_PAYLOAD;
        for (int i = 0; i < n && i < MAX_PAYLOAD; i++)
            if (!written[i] || $urandom_range(0, 1))
                write_payload(i, 8'($urandom));
        ack = $urandom_range(0, 9) < 7;
        if (ack && $urandom_range(0, 9) == 0)
            send_frame($urandom_range(0, n < MAX_PAYLOAD ? n : MAX_PAYLOAD), 1'b1,
                       8'($urandom));
        send_frame(n, ack, 8'($urandom));
        if (ack)
            answer_ack($urandom_range(0, 4));
    endtask

    task automatic noise();
        int top;
        case ($urandom_range(0, 3))
            0: write_payload($urandom_range(0, MAX_PAYLOAD - 1), 8'($urandom));
            1: feed_rx(8'($urandom));
            2: poll_tick();
            default:
            begin
                top = written_prefix();
                send_frame($urandom_range(0, top == MAX_PAYLOAD ? 63 : top), 1'($urandom),
                           8'($urandom));
            end
        endcase
    endtask

    initial
    begin
        int          pick;
        int          target;
        logic [7:0]  src;
        logic [7:0]  dst;
        logic [7:0]  polls;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_payload(0, 8'hFF);
        write_payload(1, 8'h00);
        write_payload(2, 8'hA5);
        write_payload(3, 8'h5A);
        write_payload(31, 8'h80);
        send_frame(0, 1'b0, 8'h00);
        send_frame(4, 1'b1, 8'hFF);
        feed_rx(sb.dst_id);
        feed_rx(sb.src_id);
        feed_rx(sb.exp_len);
        feed_rx(sb.exp_par);
        poll_tick();
        send_frame(2, 1'b1, 8'h3C);
        repeat (sb.poll_limit) poll_tick();
        poll_tick();
        send_frame(1, 1'b1, 8'h81);
        feed_rx(~sb.dst_id);
        feed_rx(sb.src_id);
        feed_rx(sb.exp_len);
        feed_rx(sb.exp_par);
        poll_tick();
        send_frame(3, 1'b1, 8'h7E);
        send_frame(0, 1'b0, 8'hC3);
        settle();
        write_reg(REG_ACK_POLLS, 8'h00);
        cfg_valid <= 1'b0;
        send_frame(1, 1'b1, 8'h42);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    src   = 8'h00;
                    dst   = 8'hFF;
                    polls = 8'h01;
                end
                1:
                begin
                    src   = 8'hFF;
                    dst   = 8'h00;
                    polls = 8'hFF;
                end
                default:
                begin
                    src   = 8'($urandom);
                    dst   = 8'($urandom);
                    polls = {4'($urandom), 4'($urandom_range(1, 15))};
                end
            endcase
            configure(src, dst, polls);
            if (p == 3)
                hold_req = 1'b1;
            target = work_items + PHASE_ITEMS;
            while (work_items < target)
            begin
                tx_idle = (p != PHASES - 1) && $urandom_range(0, 3) != 0;
                rx_idle = (p != PHASES - 1) && $urandom_range(0, 3) != 0;
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    exchange();
                else if (pick < 62)
                begin
                    repeat ($urandom_range(RX_LEN - 4, RX_LEN + 6)) feed_rx(8'($urandom));
                    poll_tick();
                end
                else
                    noise();
            end
        end

        settle();
        repeat (16) @(posedge clk);
        if (sb.due_results.size() != 0)
            sb.report($sformatf("%0d predicted results never arrived", sb.due_results.size()));
        if (sb.errors == 0)
            $display("[command_frame_sender_ack_checker_core] OK");
        else
            $display("[command_frame_sender_ack_checker_core] ERROR");
        $finish;
    end

endmodule
